// ===== src/dcd_pkg.sv =====
// Package for the day count to date converter: widths, reset values,
// sequencer states and the month length table. No dependencies.
`timescale 1ns / 1ps

package dcd_pkg;

  localparam int COUNT_BITS_DEF = 20;
  localparam int YEAR_BITS      = 14;
  localparam int MONTH_BITS     = 4;
  localparam int DAY_BITS       = 5;
  localparam int APB_DATA_BITS  = 32;
  localparam int APB_ADDR_BITS  = 2;

  localparam logic [YEAR_BITS-1:0]     BASE_YEAR_RST = YEAR_BITS'(2000);
  localparam logic [APB_ADDR_BITS-1:0] REG_BASE_YEAR = '0;

  // Days in a common and a leap year, and the century length.
  localparam int DAYS_COMMON  = 365;
  localparam int DAYS_LEAP    = 366;
  localparam int CENTURY      = 100;
  localparam int DIV_STEPS    = 8;   // quotient bits of base_year / 100

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_YEAR,
    ST_MONTH,
    ST_HOLD
  } dcd_state_t;

  // Month index 0 is January.
  function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                    input logic leap);
    logic [DAY_BITS-1:0] len;
    case (m) inside
      4'd1:                   len = leap ? DAY_BITS'(29) : DAY_BITS'(28);
      4'd3, 4'd5, 4'd8, 4'd10: len = DAY_BITS'(30);
      default:                len = DAY_BITS'(31);
    endcase
    return len;
  endfunction

endpackage

// ===== src/dcd_in_if.sv =====
// Input channel of the day count to date converter: valid/ready plus day_count.
// Depends on dcd_pkg.
`timescale 1ns / 1ps

interface dcd_in_if #(
  parameter int COUNT_BITS = dcd_pkg::COUNT_BITS_DEF
);
  import dcd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] day_count;

  modport source (output valid, output day_count, input ready);
  modport sink   (input valid, input day_count, output ready);
endinterface

// ===== src/dcd_out_if.sv =====
// Result channel of the day count to date converter: valid/ready plus the date.
// Depends on dcd_pkg.
`timescale 1ns / 1ps

interface dcd_out_if;
  import dcd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [YEAR_BITS-1:0]  year;
  logic [MONTH_BITS-1:0] month;
  logic [DAY_BITS-1:0]   day;

  modport source (output valid, output year, output month, output day, input ready);
  modport sink   (input valid, input year, input month, input day, output ready);
endinterface

// ===== src/day_count_to_date.sv =====
// Top level of the day count to date converter: APB register, sequencer and
// the shared subtract/compare unit. Depends on dcd_pkg, dcd_in_if, dcd_out_if.
`timescale 1ns / 1ps

// Converts a day count into the Gregorian date that many days after January 1
// of base_year (APB register at byte address 0, reset 2000). One item at a time:
// an item first splits base_year into century and year-in-century, then
// consumes whole years until the year search ends, then whole months, and
// then loads the result; the sequencer returns to idle before the next
// transfer is taken. Every step goes through a single subtract/compare unit.
// in_if.ready is high only while no item is in progress; a finished date waits
// in the output register and the next item is taken meanwhile.
// The year field is the full year wrapped to 14 bits.
module day_count_to_date #(
  parameter int COUNT_BITS = dcd_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  dcd_in_if.sink                               in_if,
  dcd_out_if.source                            out_if,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dcd_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [dcd_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [dcd_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);
  import dcd_pkg::*;

  // Operand width of the shared unit: day count or 100 << 7.
  localparam int AW    = (COUNT_BITS > 15) ? COUNT_BITS : 15;
  localparam int YADD  = (COUNT_BITS - 8 > YEAR_BITS) ? COUNT_BITS - 8 : YEAR_BITS;
  localparam int YW    = YADD + 1;
  localparam int KW    = $clog2(DIV_STEPS);

  // ---------------- configuration register ----------------
  logic [YEAR_BITS-1:0] base_year_r;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_BASE_YEAR);
  assign prdata = (paddr == REG_BASE_YEAR) ? APB_DATA_BITS'(base_year_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_year_r <= BASE_YEAR_RST;
    end else if (cfg_wr) begin
      base_year_r <= pwdata[YEAR_BITS-1:0];
    end
  end

  // ---------------- state and datapath registers ----------------
  dcd_state_t state_r, state_nxt;

  logic [COUNT_BITS-1:0] left_r, left_nxt;
  logic [YW-1:0]         y_r, y_nxt;
  logic [YEAR_BITS-1:0]  rem_r, rem_nxt;   // base_year % 100 after the split, then year % 100
  logic [1:0]            q_r, q_nxt;       // (year / 100) % 4
  logic [KW-1:0]         k_r, k_nxt;
  logic [MONTH_BITS-1:0] m_r, m_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [YEAR_BITS-1:0]  out_year_r;
  logic [MONTH_BITS-1:0] out_month_r;
  logic [DAY_BITS-1:0]   out_day_r;

  // ---------------- shared subtract/compare unit ----------------
  logic [AW-1:0] op_a, op_b;
  logic [AW:0]   diff;
  logic          ge;
  logic          leap;
  logic          accept;
  logic          slot_free;
  logic          done;
  logic          load_out;

  assign leap = ((y_r[1:0] == 2'd0) && (rem_r != '0)) || ((rem_r == '0) && (q_r == 2'd0));

  always_comb begin
    case (state_r)
      ST_DIV: begin
        op_a = AW'(rem_r);
        op_b = AW'(CENTURY) << k_r;
      end
      ST_YEAR: begin
        op_a = AW'(left_r);
        op_b = leap ? AW'(DAYS_LEAP) : AW'(DAYS_COMMON);
      end
      default: begin
        op_a = AW'(left_r);
        op_b = AW'(month_len(m_r, leap));
      end
    endcase
  end

  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = !diff[AW];

  assign accept    = in_if.valid && in_if.ready;
  assign slot_free = !out_valid_r || out_if.ready;
  assign done      = (state_r == ST_HOLD) || ((state_r == ST_MONTH) && !ge);
  assign load_out  = done && slot_free;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_DIV;
      ST_DIV:   if (k_r == '0) state_nxt = ST_YEAR;
      ST_YEAR:  if (!ge) state_nxt = ST_MONTH;
      ST_MONTH: if (!ge) state_nxt = slot_free ? ST_IDLE : ST_HOLD;
      ST_HOLD:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- outputs ----------------
  always_comb begin
    in_if.ready = (state_r == ST_IDLE);
  end

  assign out_if.valid = out_valid_r;
  assign out_if.year  = out_year_r;
  assign out_if.month = out_month_r;
  assign out_if.day   = out_day_r;

  // ---------------- datapath next values ----------------
  always_comb begin
    left_nxt      = left_r;
    y_nxt         = y_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    k_nxt         = k_r;
    m_nxt         = m_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          left_nxt = in_if.day_count;
          y_nxt    = YW'(base_year_r);
          rem_nxt  = base_year_r;
          q_nxt    = 2'd0;
          k_nxt    = KW'(DIV_STEPS - 1);
          m_nxt    = '0;
        end
      end
      ST_DIV: begin
        // restoring division by 100, keep only the low two quotient bits
        if (ge) begin
          rem_nxt = diff[YEAR_BITS-1:0];
        end
        q_nxt = {q_r[0], ge};
        k_nxt = k_r - KW'(1);
      end
      ST_YEAR, ST_MONTH: begin
        if (ge) begin
          left_nxt = diff[COUNT_BITS-1:0];
          if (state_r == ST_MONTH && m_r != MONTH_BITS'(11)) begin
            m_nxt = m_r + MONTH_BITS'(1);
          end else begin
            // advance one year, wrapping December to January
            m_nxt = '0;
            y_nxt = y_r + YW'(1);
            if (rem_r == YEAR_BITS'(CENTURY - 1)) begin
              rem_nxt = '0;
              q_nxt   = q_r + 2'd1;
            end else begin
              rem_nxt = rem_r + YEAR_BITS'(1);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    y_r    <= y_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    k_r    <= k_nxt;
    m_r    <= m_nxt;
    if (load_out) begin
      out_year_r  <= y_r[YEAR_BITS-1:0];
      out_month_r <= m_r + MONTH_BITS'(1);
      out_day_r   <= left_r[DAY_BITS-1:0] + DAY_BITS'(1);
    end
  end

  // ---------------- assertions ----------------
  a_century_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_YEAR || state_r == ST_MONTH) |-> rem_r < YEAR_BITS'(CENTURY))
    else $error("year-in-century counter out of range");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> m_r < MONTH_BITS'(12))
    else $error("month index out of range");

  a_day_fits: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> left_r < COUNT_BITS'(31))
    else $error("remaining days exceed a month at completion");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_DIV)
    else $error("accepted transfer did not start the sequencer");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> $stable(out_year_r) && $stable(out_day_r))
    else $error("pending result overwritten");

endmodule
